// File: rtl/core/l2srgb_pkg.sv
// shared types and fixed constants for the linear rgba to srgb8 pixel encoder
// no dependencies; imported by l2srgb_channel and linear_rgba_to_srgb8_pixel
`timescale 1ns / 1ps

package l2srgb_pkg;

  // fraction bits of the curve table entries
  localparam int CurveBits = 16;

  // floor(255 * 12.92 * l) is floor(32946 * raw / (10 * 2^frac))
  localparam int LinGain = 32946;
  // n / 10 as (n * 205) >> 11, exact for n below 1029
  localparam int Div10Mul = 205;
  localparam int Div10Shift = 11;

  // 255 * (1.055 * g - 0.055) scaled by 1000
  localparam int PowGain = 269025;
  localparam int PowOffset = 14025;
  // w / 1000 as (w * 268436) >> 28, exact for w below 2^18
  localparam int RecipMul = 268436;
  localparam int RecipShift = 28;

  // load enables of the five pipeline stages
  typedef struct packed {
    logic s0;
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } l2srgb_ld_t;

endpackage

// File: rtl/core/l2srgb_channel.sv
// one color channel of the srgb encoder: five stage pipeline with the curve rom
// depends on l2srgb_pkg (constants, stage load struct)
`timescale 1ns / 1ps

module l2srgb_channel import l2srgb_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int CURVE_TABLE_ENTRIES = 1024
) (
  input  logic                        clk,
  input  l2srgb_ld_t                  ld,
  input  logic signed [FRAC_BITS+1:0] linear,
  output logic [7:0]                  srgb
);

  localparam int InW = FRAC_BITS + 2;
  localparam int IdxW = $clog2(CURVE_TABLE_ENTRIES + 1);
  localparam int CurveW = CurveBits + 1;
  localparam int PosW = FRAC_BITS + IdxW;
  localparam int LinW = FRAC_BITS + 16;
  localparam int StepW = CurveW + FRAC_BITS;
  localparam int NumW = CurveW + 19;
  localparam int HiW = NumW - CurveBits;
  localparam int QW = HiW + 19;
  localparam logic [FRAC_BITS-1:0] LinLimit =
    FRAC_BITS'(((64'd31308 << FRAC_BITS) + 64'd9999999) / 64'd10000000);
  localparam logic [IdxW-1:0] Entries = IdxW'(CURVE_TABLE_ENTRIES);
  localparam real InvEntries = 1.0 / real'(CURVE_TABLE_ENTRIES);
  localparam real CurveExp = 5.0 / 12.0;

  typedef enum logic [1:0] {CAT_ZERO, CAT_LIN, CAT_POW, CAT_ONE} cat_t;
  typedef logic [CurveW-1:0] curve_rom_t [0:CURVE_TABLE_ENTRIES];

  // exact test t^12 * N^5 <= i^5 * 2^(12*16), evaluated at elaboration only
  function automatic logic root_fits(input int unsigned t, input int unsigned i);
    logic [319:0] lhs;
    logic [319:0] rhs;
    int k;
    lhs = 320'd1;
    rhs = 320'd1;
    for (k = 0; k < 12; k++) lhs = lhs * 320'(t);
    for (k = 0; k < 5; k++) lhs = lhs * 320'(CURVE_TABLE_ENTRIES);
    for (k = 0; k < 5; k++) rhs = rhs * 320'(i);
    rhs = rhs << (12 * CurveBits);
    return lhs <= rhs;
  endfunction

  // floor(2^16 * (i/N)^(5/12)); real estimate then exact correction
  function automatic curve_rom_t build_curve();
    curve_rom_t rom;
    real x;
    int unsigned v;
    int unsigned i;
    for (i = 0; i <= CURVE_TABLE_ENTRIES; i++) begin
      x = $pow(real'(i) * InvEntries, CurveExp) * 65536.0;
      v = $rtoi(x);
      if (v > 65536) v = 65536;
      if (v < 65536 && root_fits(v + 1, i)) begin
        v = v + 1;
      end else if (v > 0 && !root_fits(v, i)) begin
        v = v - 1;
      end
      rom[i] = CurveW'(v);
    end
    return rom;
  endfunction

  localparam curve_rom_t Curve = build_curve();

  // stage 0: input register
  logic signed [InW-1:0] lin0;
  logic [FRAC_BITS-1:0]  u0;
  cat_t                  cat0;
  logic [LinW-1:0]       lin_prod0;
  logic [PosW-1:0]       pos_prod0;
  logic [IdxW-1:0]       idx0;

  // stage 1: rom read data
  logic [CurveW-1:0]    lo1;
  logic [CurveW-1:0]    hi1;
  logic [FRAC_BITS-1:0] frac1;
  cat_t                 cat1;
  logic [7:0]           lin1;
  logic [CurveW-1:0]    diff1;
  logic [StepW-1:0]     step_prod1;
  logic [15:0]          ten_prod1;

  // stage 2: interpolated curve value
  logic [CurveW-1:0] g2;
  cat_t              cat2;
  logic [7:0]        lin2;

  // stage 3: scaled curve value
  logic [NumW-1:0] num3;
  cat_t            cat3;
  logic [7:0]      lin3;
  logic [HiW-1:0]  hi3;
  logic [HiW-1:0]  w3;
  logic [QW-1:0]   q_prod3;
  logic [8:0]      q3;
  logic [7:0]      pow_byte3;

  always_ff @(posedge clk) begin
    if (ld.s0) begin
      lin0 <= linear;
    end
  end

  always_comb begin
    u0 = lin0[FRAC_BITS-1:0];
    if (lin0[InW-1] || lin0 == '0) begin
      cat0 = CAT_ZERO;
    end else if (lin0[FRAC_BITS]) begin
      cat0 = CAT_ONE;
    end else if (u0 < LinLimit) begin
      cat0 = CAT_LIN;
    end else begin
      cat0 = CAT_POW;
    end
    lin_prod0 = {16'd0, u0} * LinW'(LinGain);
    pos_prod0 = {{IdxW{1'b0}}, u0} * {{FRAC_BITS{1'b0}}, Entries};
    idx0 = pos_prod0[PosW-1:FRAC_BITS];
  end

  // curve rom, two read ports with registered data
  always_ff @(posedge clk) begin
    if (ld.s1) begin
      lo1   <= Curve[idx0];
      hi1   <= Curve[idx0 + 1'b1];
      frac1 <= pos_prod0[FRAC_BITS-1:0];
      cat1  <= cat0;
      lin1  <= lin_prod0[FRAC_BITS+7:FRAC_BITS];
    end
  end

  always_comb begin
    diff1 = hi1 - lo1;
    step_prod1 = {{FRAC_BITS{1'b0}}, diff1} * {{CurveW{1'b0}}, frac1};
    ten_prod1 = {8'd0, lin1} * 16'(Div10Mul);
  end

  always_ff @(posedge clk) begin
    if (ld.s2) begin
      g2   <= lo1 + step_prod1[StepW-1:FRAC_BITS];
      cat2 <= cat1;
      lin2 <= 8'(ten_prod1 >> Div10Shift);
    end
  end

  always_ff @(posedge clk) begin
    if (ld.s3) begin
      num3 <= {19'd0, g2} * NumW'(PowGain);
      cat3 <= cat2;
      lin3 <= lin2;
    end
  end

  // the offset is a whole multiple of 2^16, so it comes off the upper part
  always_comb begin
    hi3 = num3[NumW-1:CurveBits];
    w3 = hi3 - HiW'(PowOffset);
    q_prod3 = {19'd0, w3} * QW'(RecipMul);
    q3 = q_prod3[RecipShift+8:RecipShift];
    if (hi3 <= HiW'(PowOffset)) begin
      pow_byte3 = 8'd0;
    end else if (q3[8]) begin
      pow_byte3 = 8'd255;
    end else begin
      pow_byte3 = q3[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld.s4) begin
      case (cat3)
        CAT_ZERO: srgb <= 8'd0;
        CAT_LIN:  srgb <= lin3;
        CAT_POW:  srgb <= pow_byte3;
        CAT_ONE:  srgb <= 8'd255;
        default:  srgb <= 8'd0;
      endcase
    end
  end

endmodule

// File: rtl/core/linear_rgba_to_srgb8_pixel.sv
// Linear RGBA to 8-bit sRGB pixel encoder. Each of red, green and blue goes
// through the sRGB transfer curve (linear segment near black, an interpolated
// table of x^(5/12) above it), is clamped to 0..1 and scaled to a byte; alpha is
// scaled by 255 and saturated; the pixel coordinates ride along unchanged. One
// pixel beat is accepted every clock while the output is not stalled, and a
// result goes through each pipeline stage in turn; the stage count is set by the
// registered read of the per-channel curve ROM (CURVE_TABLE_ENTRIES+1 entries,
// two read ports) and the three multiplies that follow it. The ROM is a constant
// and needs no load after reset. Input tdata, from bit 0: red, green, blue,
// alpha (each FRAC_BITS+2 bits two's complement), x, y (COORD_BITS each).
// depends on l2srgb_pkg and l2srgb_channel
`timescale 1ns / 1ps

module linear_rgba_to_srgb8_pixel import l2srgb_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int CURVE_TABLE_ENTRIES = 1024,
  parameter int COORD_BITS = 12
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // linear_red, linear_green, linear_blue, linear_alpha, pixel_x, pixel_y, zero pad
  input  logic [(((4*(FRAC_BITS+2)+2*COORD_BITS+7) >> 3) << 3)-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // srgb_red, srgb_green, srgb_blue, alpha_byte, out_x, out_y, zero pad
  output logic [(((32+2*COORD_BITS+7) >> 3) << 3)-1:0] m_axis_tdata
);

  localparam int FieldW = FRAC_BITS + 2;
  localparam int OutW = ((32 + 2 * COORD_BITS + 7) / 8) * 8;
  localparam int AlphaW = FRAC_BITS + 9;

  typedef struct packed {
    logic signed [FieldW-1:0] alpha;
    logic [COORD_BITS-1:0]    x;
    logic [COORD_BITS-1:0]    y;
  } side_in_t;

  typedef struct packed {
    logic [7:0]            alpha;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } side_t;

  l2srgb_ld_t  ld;
  logic [4:0]  stage_valid;
  side_in_t    side0;
  side_t       side [1:4];
  logic [AlphaW-1:0] alpha_prod;
  logic [7:0]  alpha_byte0;
  logic [7:0]  srgb_red;
  logic [7:0]  srgb_green;
  logic [7:0]  srgb_blue;

  // a stage loads when it is empty or its beat moves on
  always_comb begin
    ld.s4 = !stage_valid[4] || m_axis_tready;
    ld.s3 = !stage_valid[3] || ld.s4;
    ld.s2 = !stage_valid[2] || ld.s3;
    ld.s1 = !stage_valid[1] || ld.s2;
    ld.s0 = !stage_valid[0] || ld.s1;
  end

  assign s_axis_tready = ld.s0;
  assign m_axis_tvalid = stage_valid[4];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (ld.s0) stage_valid[0] <= s_axis_tvalid;
      if (ld.s1) stage_valid[1] <= stage_valid[0];
      if (ld.s2) stage_valid[2] <= stage_valid[1];
      if (ld.s3) stage_valid[3] <= stage_valid[2];
      if (ld.s4) stage_valid[4] <= stage_valid[3];
    end
  end

  l2srgb_channel #(
    .FRAC_BITS(FRAC_BITS),
    .CURVE_TABLE_ENTRIES(CURVE_TABLE_ENTRIES)
  ) u_red (
    .clk(clk),
    .ld(ld),
    .linear(s_axis_tdata[FieldW-1:0]),
    .srgb(srgb_red)
  );

  l2srgb_channel #(
    .FRAC_BITS(FRAC_BITS),
    .CURVE_TABLE_ENTRIES(CURVE_TABLE_ENTRIES)
  ) u_green (
    .clk(clk),
    .ld(ld),
    .linear(s_axis_tdata[2*FieldW-1:FieldW]),
    .srgb(srgb_green)
  );

  l2srgb_channel #(
    .FRAC_BITS(FRAC_BITS),
    .CURVE_TABLE_ENTRIES(CURVE_TABLE_ENTRIES)
  ) u_blue (
    .clk(clk),
    .ld(ld),
    .linear(s_axis_tdata[3*FieldW-1:2*FieldW]),
    .srgb(srgb_blue)
  );

  // alpha and coordinates travel beside the color channels
  always_ff @(posedge clk) begin
    if (ld.s0) begin
      side0.alpha <= s_axis_tdata[4*FieldW-1:3*FieldW];
      side0.x     <= s_axis_tdata[4*FieldW+COORD_BITS-1:4*FieldW];
      side0.y     <= s_axis_tdata[4*FieldW+2*COORD_BITS-1:4*FieldW+COORD_BITS];
    end
  end

  always_comb begin
    alpha_prod = {8'd0, side0.alpha[FRAC_BITS:0]} * AlphaW'(255);
    if (side0.alpha[FieldW-1] || side0.alpha == '0) begin
      alpha_byte0 = 8'd0;
    end else if (alpha_prod[AlphaW-1]) begin
      alpha_byte0 = 8'd255;
    end else begin
      alpha_byte0 = alpha_prod[FRAC_BITS+7:FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (ld.s1) side[1] <= '{alpha: alpha_byte0, x: side0.x, y: side0.y};
    if (ld.s2) side[2] <= side[1];
    if (ld.s3) side[3] <= side[2];
    if (ld.s4) side[4] <= side[3];
  end

  assign m_axis_tdata = OutW'({side[4].y, side[4].x, side[4].alpha,
                               srgb_blue, srgb_green, srgb_red});

`ifndef SYNTHESIS
  // with the output empty every stage can move, so the input is never blocked
  assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked while output stage is empty");

  assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid && stage_valid == '0)
    else $error("pipeline holds beats right after reset");

  // a result only appears from the stage before the output
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(stage_valid[3]))
    else $error("output beat appeared without a beat in stage three");

  assert property (@(posedge clk) disable iff (rst)
    (stage_valid[3] && !ld.s4) |=> stage_valid[3] && stage_valid[4])
    else $error("stalled beat lost ahead of the output stage");
`endif

endmodule
